>>> hdl/s64alu_pkg.sv
// Shared types, operation codes and state encoding for the signed 64-bit ALU.
`default_nettype none

package s64alu_pkg;

  localparam int HALF_WIDTH_DEF = 32;
  localparam int PORT_WIDTH     = 64;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_REM = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               div_by_zero;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_MUL,
    ST_NEG_A,
    ST_NEG_B,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hdl/signed_64bit_alu_from_32bit_halves.sv
// Signed ALU top level: sequencer and datapath around one shared adder.
// With W = 2*HALF_WIDTH (64 by default): add/sub takes a single adder pass,
//   multiply is shift-add (one bit a cycle), divide and remainder run negate a,
//   negate b, W restoring steps and sign fix, and a zero divisor or unused mode
//   goes to done. The next start is taken in the cycle out_valid is high.
// rst_n is synchronous and returns the sequencer to idle; no result is emitted.
`default_nettype none

module signed_64bit_alu_from_32bit_halves #(
  parameter int HALF_WIDTH = s64alu_pkg::HALF_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire s64alu_pkg::in_t   in_data,
  output logic                   busy,
  output logic                   out_valid,
  output s64alu_pkg::out_t       out_data
);

  localparam int W  = 2 * HALF_WIDTH;
  localparam int AW = W + 1;
  localparam int CW = $clog2(W);
  localparam int PW = s64alu_pkg::PORT_WIDTH;
  localparam logic [W-1:0] ZERO_DIV_Q = {{HALF_WIDTH{1'b1}}, {HALF_WIDTH{1'b0}}};

  s64alu_pkg::state_t state_r, state_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic [W-1:0]       opa_r, opa_nxt;
  logic [W-1:0]       opb_r, opb_nxt;
  logic [W-1:0]       acc_r, acc_nxt;
  logic [W-1:0]       quo_r, quo_nxt;
  logic signed [W-1:0] res_r, res_nxt;
  logic               dz_r, dz_nxt;
  logic               neg_a_r, neg_a_nxt;
  logic               neg_b_r, neg_b_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic [AW-1:0]      add_x, add_y, add_sum;
  logic               add_cin, add_cout;

  logic               accept;
  logic               last;
  logic [W-1:0]       in_a, in_b;
  logic [AW-1:0]      trial;
  logic [W-1:0]       mul_acc;
  logic [W-1:0]       fix_val;
  logic               fix_neg;

  assign busy    = !(state_r == s64alu_pkg::ST_IDLE || state_r == s64alu_pkg::ST_DONE);
  assign accept  = start && !busy;
  assign last    = (cnt_r == CW'(W - 1));
  assign in_a    = in_data.operand_a[W-1:0];
  assign in_b    = in_data.operand_b[W-1:0];
  assign trial   = {acc_r, quo_r[W-1]};
  assign mul_acc = opb_r[0] ? add_sum[W-1:0] : acc_r;
  assign fix_val = (mode_r == s64alu_pkg::MODE_DIV) ? quo_r : acc_r;
  assign fix_neg = (mode_r == s64alu_pkg::MODE_DIV) ? (neg_a_r ^ neg_b_r) : neg_a_r;

  s64alu_adder #(
    .WIDTH(AW)
  ) u_adder (
    .a    (add_x),
    .b    (add_y),
    .cin  (add_cin),
    .sum  (add_sum),
    .cout (add_cout)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      s64alu_pkg::ST_IDLE, s64alu_pkg::ST_DONE: begin
        state_nxt = s64alu_pkg::ST_IDLE;
        if (accept) begin
          if (in_data.mode inside {s64alu_pkg::MODE_ADD, s64alu_pkg::MODE_SUB}) begin
            state_nxt = s64alu_pkg::ST_ADDSUB;
          end else if (in_data.mode == s64alu_pkg::MODE_MUL) begin
            state_nxt = s64alu_pkg::ST_MUL;
          end else if (in_data.mode inside {s64alu_pkg::MODE_DIV, s64alu_pkg::MODE_REM}
                       && in_b != '0) begin
            state_nxt = s64alu_pkg::ST_NEG_A;
          end else begin
            state_nxt = s64alu_pkg::ST_DONE;
          end
        end
      end
      s64alu_pkg::ST_ADDSUB: state_nxt = s64alu_pkg::ST_DONE;
      s64alu_pkg::ST_MUL:    state_nxt = last ? s64alu_pkg::ST_DONE : s64alu_pkg::ST_MUL;
      s64alu_pkg::ST_NEG_A:  state_nxt = s64alu_pkg::ST_NEG_B;
      s64alu_pkg::ST_NEG_B:  state_nxt = s64alu_pkg::ST_DIV;
      s64alu_pkg::ST_DIV:    state_nxt = last ? s64alu_pkg::ST_FIX : s64alu_pkg::ST_DIV;
      s64alu_pkg::ST_FIX:    state_nxt = s64alu_pkg::ST_DONE;
      default:               state_nxt = s64alu_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and adder operand selection
  always_comb begin
    mode_nxt  = mode_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    acc_nxt   = acc_r;
    quo_nxt   = quo_r;
    res_nxt   = res_r;
    dz_nxt    = dz_r;
    neg_a_nxt = neg_a_r;
    neg_b_nxt = neg_b_r;
    cnt_nxt   = cnt_r;
    add_x     = '0;
    add_y     = '0;
    add_cin   = 1'b0;
    case (state_r)
      s64alu_pkg::ST_IDLE, s64alu_pkg::ST_DONE: begin
        if (accept) begin
          mode_nxt  = in_data.mode;
          opa_nxt   = in_a;
          opb_nxt   = in_b;
          acc_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          neg_a_nxt = in_a[W-1];
          neg_b_nxt = in_b[W-1];
          dz_nxt    = 1'b0;
          res_nxt   = '0;
          if (in_b == '0 && in_data.mode == s64alu_pkg::MODE_DIV) begin
            dz_nxt  = 1'b1;
            res_nxt = ZERO_DIV_Q;
          end else if (in_b == '0 && in_data.mode == s64alu_pkg::MODE_REM) begin
            dz_nxt  = 1'b1;
            res_nxt = in_a;
          end
        end
      end
      s64alu_pkg::ST_ADDSUB: begin
        add_x   = {1'b0, opa_r};
        add_cin = (mode_r == s64alu_pkg::MODE_SUB);
        add_y   = add_cin ? {1'b0, ~opb_r} : {1'b0, opb_r};
        res_nxt = add_sum[W-1:0];
      end
      s64alu_pkg::ST_MUL: begin
        // add shifted multiplicand when the current multiplier bit is set
        add_x   = {1'b0, acc_r};
        add_y   = {1'b0, opa_r};
        acc_nxt = mul_acc;
        res_nxt = mul_acc;
        opa_nxt = {opa_r[W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[W-1:1]};
        cnt_nxt = cnt_r + CW'(1);
      end
      s64alu_pkg::ST_NEG_A: begin
        add_y   = {1'b0, ~opa_r};
        add_cin = 1'b1;
        quo_nxt = neg_a_r ? add_sum[W-1:0] : opa_r;
      end
      s64alu_pkg::ST_NEG_B: begin
        add_y   = {1'b0, ~opb_r};
        add_cin = 1'b1;
        opb_nxt = neg_b_r ? add_sum[W-1:0] : opb_r;
      end
      s64alu_pkg::ST_DIV: begin
        // restoring step: carry out means the partial remainder covers the divisor
        add_x   = trial;
        add_y   = ~{1'b0, opb_r};
        add_cin = 1'b1;
        acc_nxt = add_cout ? add_sum[W-1:0] : trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], add_cout};
        cnt_nxt = cnt_r + CW'(1);
      end
      s64alu_pkg::ST_FIX: begin
        add_y   = {1'b0, ~fix_val};
        add_cin = 1'b1;
        res_nxt = fix_neg ? add_sum[W-1:0] : fix_val;
      end
      default: begin
        add_cin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= s64alu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    opa_r   <= opa_nxt;
    opb_r   <= opb_nxt;
    acc_r   <= acc_nxt;
    quo_r   <= quo_nxt;
    res_r   <= res_nxt;
    dz_r    <= dz_nxt;
    neg_a_r <= neg_a_nxt;
    neg_b_r <= neg_b_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign out_valid = (state_r == s64alu_pkg::ST_DONE);
  assign out_data  = {PW'(res_r), dz_r};

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("strobe or busy after reset");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy || out_valid)
    else $error("accepted beat dropped");

  // an operation that goes straight to done, taken in the strobe cycle, strobes again right away
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !accept |=> !out_valid)
    else $error("result strobe held two cycles");

  a_div_loop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == s64alu_pkg::ST_DIV && !last |=> state_r == s64alu_pkg::ST_DIV)
    else $error("divide loop left early");

  a_dz_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_by_zero |->
      (mode_r == s64alu_pkg::MODE_DIV || mode_r == s64alu_pkg::MODE_REM))
    else $error("zero-divisor flag on non-divide op");

endmodule

`default_nettype wire

>>> hdl/s64alu_adder.sv
// Shared adder with carry in and carry out for the ALU busy states.
`default_nettype none

module s64alu_adder #(
  parameter int WIDTH = 2 * s64alu_pkg::HALF_WIDTH_DEF + 1
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic             cin,
  output logic      [WIDTH-1:0] sum,
  output logic                  cout
);

  assign {cout, sum} = {1'b0, a} + {1'b0, b} + {{WIDTH{1'b0}}, cin};

endmodule

`default_nettype wire
